### rtl/core/jdas_pkg.sv
// Package for the JTAG DAP access scan: payload types, scan timing constants, TMS tables.
`timescale 1ns / 1ps
package jdas_pkg;

   // Instruction register length of the target TAP
   localparam int IR_LENGTH = 4;

   // Scan layout, in ticks
   localparam int DR_BITS    = 35;
   localparam int PRE_TICKS  = 10;
   localparam int MID_TICKS  = 4;
   localparam int POS_W      = 6;
   localparam int LEAD_IDX_W = $clog2(PRE_TICKS);
   localparam int MID_IDX_W  = $clog2(MID_TICKS);

   localparam logic [POS_W-1:0] IR_START   = POS_W'(PRE_TICKS);
   localparam logic [POS_W-1:0] IR_END     = POS_W'(PRE_TICKS + IR_LENGTH);
   localparam logic [POS_W-1:0] DR_START   = POS_W'(PRE_TICKS + IR_LENGTH + MID_TICKS);
   localparam logic [POS_W-1:0] POST_START =
      POS_W'(PRE_TICKS + IR_LENGTH + MID_TICKS + DR_BITS);
   localparam logic [POS_W-1:0] SCAN_LAST  =
      POS_W'(PRE_TICKS + IR_LENGTH + MID_TICKS + DR_BITS + 1);

   // TMS of lead-in ticks, bit i for tick i: 1,1,1,1,1,0,1,1,0,0
   localparam logic [PRE_TICKS-1:0] LEAD_TMS = 10'b0011011111;
   // TMS from Exit1-IR to Shift-DR, bit i for tick i: 1,1,0,0
   localparam logic [MID_TICKS-1:0] MID_TMS  = 4'b0011;

   // Input queue depth
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  ir_code;
      logic [1:0]  reg_addr;
      logic        read_not_write;
      logic [31:0] write_data;
      logic        tdo;
   } req_type;

   typedef struct packed {
      logic        tms;
      logic        tdi;
      logic        last;
      logic [2:0]  ack;
      logic [31:0] read_data;
   } rsp_type;

   // Classified queue entry
   typedef struct packed {
      logic        is_start;
      logic [3:0]  ir_code;
      logic [1:0]  reg_addr;
      logic        read_not_write;
      logic [31:0] write_data;
      logic        tdo;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

### rtl/core/jtag_dap_access_scan.sv
// Top level of the JTAG DAP access scan sequencer.
// A start transfer latches one DP/AP access (IR code, A[3:2], RnW, write data) and yields
// no result; each following tick transfer yields one result with the TMS/TDI levels for
// that TCK cycle. A scan is 51 + IR_LENGTH ticks (55 here); on the final tick last is set
// and ack/read_data carry the TDO captured during the 35-bit DR shift. A start during a
// scan restarts it; ticks while idle are dropped. Requests pass through a two-entry queue
// to the sequencer, which retires one entry per clock whenever its result register is
// free or being taken, so a transfer can be accepted every cycle.
`timescale 1ns / 1ps
module jtag_dap_access_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jdas_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jdas_pkg::rsp_type rsp_data
);

   jdas_pkg::q_entry_type  head;
   jdas_pkg::q_status_type status;
   logic                   pop;

   jdas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   jdas_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Queue cannot be empty and full at once
   a_q_status: assert property (@(posedge clock) disable iff (reset)
      !(status.empty && status.full))
      else $error("queue empty and full together");

   // Sequencer never retires from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   // Capture fields stay zero until the final tick
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.ack == 3'd0 && rsp_data.read_data == 32'd0))
      else $error("capture fields set before final tick");

   // Final tick returns to Run-Test/Idle with TDI low
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (!rsp_data.tms && !rsp_data.tdi))
      else $error("final tick not an idle tick");
`endif

endmodule

### rtl/core/jdas_front.sv
// Front end of the DAP access scan: accepts and classifies requests into a short queue.
`timescale 1ns / 1ps
module jdas_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jdas_pkg::req_type     req_data,
   input  logic                  pop,
   output jdas_pkg::q_entry_type head,
   output jdas_pkg::q_status_type status
);

   jdas_pkg::q_entry_type              q_ff [jdas_pkg::Q_DEPTH];
   logic [jdas_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jdas_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jdas_pkg::Q_CNT_W-1:0]       count_ff, count_in;
   logic                               push;
   jdas_pkg::q_entry_type              entry;

   // Status and handshake
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == jdas_pkg::Q_CNT_W'(jdas_pkg::Q_DEPTH));
   assign req_stall    = status.full;
   assign push         = req_valid && !req_stall;

   // Classify the request
   always_comb begin
      entry.is_start       = (req_data.opcode == jdas_pkg::OP_START);
      entry.ir_code        = req_data.ir_code;
      entry.reg_addr       = req_data.reg_addr;
      entry.read_not_write = req_data.read_not_write;
      entry.write_data     = req_data.write_data;
      entry.tdo            = req_data.tdo;
   end

   assign head = q_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == jdas_pkg::Q_PTR_W'(jdas_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == jdas_pkg::Q_PTR_W'(jdas_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### rtl/core/jdas_seq.sv
// Back end of the DAP access scan: TAP sequencer, shift registers and result register.
`timescale 1ns / 1ps
module jdas_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  jdas_pkg::q_entry_type  head,
   input  jdas_pkg::q_status_type status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jdas_pkg::rsp_type      rsp_data
);

   logic                              busy_ff, busy_in;
   logic [jdas_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [3:0]                        ir_ff, ir_in;
   logic [jdas_pkg::DR_BITS-1:0]      dr_ff, dr_in;
   logic [jdas_pkg::DR_BITS-1:0]      cap_ff, cap_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   jdas_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              can_take;
   logic                              tms, tdi, fin;
   logic [jdas_pkg::POS_W-1:0]        mid_off;

   // Take the next entry when the result register is free or draining
   assign can_take = !rsp_valid_ff || !rsp_stall;
   assign pop      = !status.empty && can_take;
   assign mid_off  = pos_ff - jdas_pkg::IR_END;

   // Tick decode
   always_comb begin
      tms   = 1'b0;
      tdi   = 1'b0;
      fin   = 1'b0;
      ir_in = ir_ff;
      dr_in = dr_ff;
      cap_in = cap_ff;
      priority if (pos_ff < jdas_pkg::IR_START) begin
         tms = jdas_pkg::LEAD_TMS[pos_ff[jdas_pkg::LEAD_IDX_W-1:0]];
      end else if (pos_ff < jdas_pkg::IR_END) begin
         tdi   = ir_ff[0];
         ir_in = {1'b0, ir_ff[3:1]};
         tms   = (pos_ff == jdas_pkg::IR_END - 1'b1);
      end else if (pos_ff < jdas_pkg::DR_START) begin
         tms = jdas_pkg::MID_TMS[mid_off[jdas_pkg::MID_IDX_W-1:0]];
      end else if (pos_ff < jdas_pkg::POST_START) begin
         tdi    = dr_ff[0];
         dr_in  = {1'b0, dr_ff[jdas_pkg::DR_BITS-1:1]};
         cap_in = {head.tdo, cap_ff[jdas_pkg::DR_BITS-1:1]};
         tms    = (pos_ff == jdas_pkg::POST_START - 1'b1);
      end else begin
         tms = (pos_ff == jdas_pkg::POST_START);
         fin = (pos_ff == jdas_pkg::SCAN_LAST);
      end
   end

   // Next state and result
   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         if (head.is_start) begin
            busy_in = 1'b1;
            pos_in  = '0;
         end else if (busy_ff) begin
            rsp_valid_in       = 1'b1;
            rsp_in.tms         = tms;
            rsp_in.tdi         = tdi;
            rsp_in.last        = fin;
            rsp_in.ack         = fin ? cap_in[2:0] : 3'd0;
            rsp_in.read_data   = fin ? cap_in[jdas_pkg::DR_BITS-1:3] : 32'd0;
            if (fin) begin
               busy_in = 1'b0;
               pos_in  = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shift registers and result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop) begin
         if (head.is_start) begin
            ir_ff <= head.ir_code;
            dr_ff <= {head.write_data, head.reg_addr, head.read_not_write};
         end else if (busy_ff) begin
            ir_ff  <= ir_in;
            dr_ff  <= dr_in;
            cap_ff <= cap_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
